/* design/lepf_pkg.sv */
// shared types, constants and ligature table for the ligature expand / punctuation fold block
`default_nettype none

package lepf_pkg;

  localparam int LIG_ROWS      = 38;
  localparam int TABLE_ENTRIES = 38;
  localparam int SEARCH_ROWS   = (TABLE_ENTRIES < LIG_ROWS) ? TABLE_ENTRIES : LIG_ROWS;
  localparam int MAX_RUN       = 3;

  // register indexes
  localparam logic [1:0] REG_LIGATURE_ENABLE   = 2'd0;
  localparam logic [1:0] REG_PUNCT_FOLD_ENABLE = 2'd1;

  // folding codes
  localparam logic [15:0] U_LSQUO  = 16'h2018;
  localparam logic [15:0] U_RSQUO  = 16'h2019;
  localparam logic [15:0] U_PRIME  = 16'h2032;
  localparam logic [15:0] U_APOS   = 16'h0027;
  localparam logic [15:0] U_LDQUO  = 16'h201C;
  localparam logic [15:0] U_RDQUO  = 16'h201D;
  localparam logic [15:0] U_LAQUO  = 16'h00AB;
  localparam logic [15:0] U_RAQUO  = 16'h00BB;
  localparam logic [15:0] U_QUOT   = 16'h0022;
  localparam logic [15:0] U_ENDASH = 16'h2013;
  localparam logic [15:0] U_EMDASH = 16'h2014;
  localparam logic [15:0] U_HYPHEN = 16'h002D;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_text;
  } lepf_in_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        run_last;
    logic        text_last;
  } lepf_out_t;

  // one decoded request: up to three units, index of the last one, end marker
  typedef struct packed {
    logic [MAX_RUN-1:0][15:0] units;
    logic [1:0]               last_idx;
    logic                     eot;
  } lepf_item_t;

  localparam logic [LIG_ROWS-1:0][15:0] LIG_UNIT = {
    16'hFB06, 16'hFB05, 16'hFB04, 16'hFB03, 16'hFB02, 16'hFB01, 16'hFB00, 16'h1D6B,
    16'h02AC, 16'h02AB, 16'h02AA, 16'h02A9, 16'h02A6, 16'h02A3, 16'h01F3, 16'h01F2,
    16'h01F1, 16'h01CC, 16'h01CB, 16'h01CA, 16'h01C9, 16'h01C8, 16'h01C7, 16'h01C6,
    16'h01C5, 16'h01C4, 16'h0195, 16'h01F6, 16'h014B, 16'h014A, 16'h0133, 16'h0132,
    16'h0276, 16'h0153, 16'h0152, 16'h00C6, 16'h00E6, 16'h00DF
  };

  // letters of each row, first letter in the top byte, unused bytes zero
  localparam logic [LIG_ROWS-1:0][23:0] LIG_TXT = {
    {"s","t",8'h00}, {"f","t",8'h00}, {"f","f","l"},   {"f","f","i"},
    {"f","l",8'h00}, {"f","i",8'h00}, {"f","f",8'h00}, {"u","e",8'h00},
    {"w","w",8'h00}, {"l","z",8'h00}, {"l","s",8'h00}, {"f","n","g"},
    {"t","s",8'h00}, {"d","z",8'h00}, {"d","z",8'h00}, {"D","z",8'h00},
    {"D","Z",8'h00}, {"n","j",8'h00}, {"N","j",8'h00}, {"N","J",8'h00},
    {"l","j",8'h00}, {"L","j",8'h00}, {"L","J",8'h00}, {"d","z",8'h00},
    {"D","z",8'h00}, {"D","Z",8'h00}, {"h","v",8'h00}, {"H","v",8'h00},
    {"n","g",8'h00}, {"N","g",8'h00}, {"i","j",8'h00}, {"I","J",8'h00},
    {"o","e",8'h00}, {"o","e",8'h00}, {"O","E",8'h00}, {"a","e",8'h00},
    {"A","E",8'h00}, {"f","s",8'h00}
  };

  // last letter index per row: 2 for three-letter rows, else 1
  localparam logic [LIG_ROWS-1:0][1:0] LIG_LAST = {
    2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
  };

  function automatic logic [15:0] fold_unit(input logic [15:0] u);
    logic [15:0] r;
    r = u;
    if (u == U_LSQUO || u == U_RSQUO || u == U_PRIME) begin
      r = U_APOS;
    end else if (u == U_LDQUO || u == U_RDQUO || u == U_LAQUO || u == U_RAQUO) begin
      r = U_QUOT;
    end else if (u == U_ENDASH || u == U_EMDASH) begin
      r = U_HYPHEN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ligature_expand_punct_fold.sv */
// top level: ligature expansion and punctuation folding of a UCS-2 stream
`default_nettype none

// Each input request carries one UCS-2 code unit. With ligature expansion on,
// a unit found in the fixed 38-row ligature table turns into its two or three
// ASCII letters, one result per cycle while out_ready is high; otherwise, with
// folding on, curly quotes, guillemets, primes and dashes become ASCII quote,
// double quote or hyphen, and anything else passes unchanged. run_last marks
// the final result of each request and text_last copies end_of_text onto it.
// The decode is a single combinational pass in front of the result register,
// so a plain unit yields one result and a ligature yields as many results as
// it has letters (2 or 3); the result register emits one unit per cycle while
// out_ready is high and is the only rate limit. A one-entry skid register
// sits between the input and the result register, so in_ready is a register
// output and a request is still taken while a result waits on out_ready.
// Configuration writes take effect on requests accepted afterwards.
module ligature_expand_punct_fold
  import lepf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire lepf_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output lepf_out_t       out_data
);

  // configuration registers
  logic lig_en_r;
  logic fold_en_r;

  // skid stage and result stage
  lepf_item_t skid_r;
  logic       skid_valid_r;
  lepf_item_t res_r;
  logic       res_valid_r;
  logic [1:0] idx_r;

  lepf_item_t dec_item;
  logic       in_fire;
  logic       out_fire;
  logic       res_last;
  logic       res_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lig_en_r  <= 1'b1;
      fold_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGATURE_ENABLE:   lig_en_r  <= cfg_wdata;
        REG_PUNCT_FOLD_ENABLE: fold_en_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lepf_decode u_decode (
    .in_item (in_data),
    .lig_en  (lig_en_r),
    .fold_en (fold_en_r),
    .item    (dec_item)
  );

  // ready only depends on the skid register
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = res_valid_r;
  assign out_fire  = out_valid && out_ready;
  assign res_last  = (idx_r == res_r.last_idx);
  // result register frees up when empty or when its final unit leaves
  assign res_adv   = !res_valid_r || (out_ready && res_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else if (res_adv) begin
      idx_r <= '0;
      if (skid_valid_r) begin
        res_r        <= skid_r;
        res_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        res_r       <= dec_item;
        res_valid_r <= in_fire;
      end
    end else begin
      if (out_fire) begin
        idx_r <= idx_r + 2'd1;
      end
      // result stage busy: park the new request
      if (in_fire) begin
        skid_r       <= dec_item;
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    out_data.out_unit = res_r.units[0];
      2'd1:    out_data.out_unit = res_r.units[1];
      2'd2:    out_data.out_unit = res_r.units[2];
      default: out_data.out_unit = res_r.units[0];
    endcase
    out_data.run_last  = res_last;
    out_data.text_last = res_last && res_r.eot;
  end

  // the letter pointer never runs past the last letter of the run
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (idx_r <= res_r.last_idx))
    else $error("letter index past end of run");

  // a parked request implies the result stage is occupied
  a_skid_behind_res: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> res_valid_r)
    else $error("skid holds a request while result stage is empty");

  // a taken non-final letter is followed by the next letter of the same run
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !res_last) |=> (out_valid && idx_r == $past(idx_r) + 2'd1))
    else $error("run broken before its last letter");

endmodule

`default_nettype wire

/* design/lepf_decode.sv */
// decode of one code unit into its run of result units
`default_nettype none

module lepf_decode
  import lepf_pkg::*;
(
  input  wire lepf_in_t   in_item,
  input  wire logic       lig_en,
  input  wire logic       fold_en,
  output lepf_item_t      item
);

  logic        hit;
  logic [23:0] txt;
  logic [1:0]  last;

  // rows are distinct, so at most one compare fires
  always_comb begin
    hit  = 1'b0;
    txt  = '0;
    last = '0;
    for (int i = 0; i < SEARCH_ROWS; i++) begin
      if (in_item.code_unit == LIG_UNIT[i]) begin
        hit  = 1'b1;
        txt  = LIG_TXT[i];
        last = LIG_LAST[i];
      end
    end
  end

  always_comb begin
    item.eot = in_item.end_of_text;
    if (lig_en && hit) begin
      item.units[0] = {8'h00, txt[23:16]};
      item.units[1] = {8'h00, txt[15:8]};
      item.units[2] = {8'h00, txt[7:0]};
      item.last_idx = last;
    end else begin
      item.units[0] = fold_en ? fold_unit(in_item.code_unit) : in_item.code_unit;
      item.units[1] = '0;
      item.units[2] = '0;
      item.last_idx = 2'd0;
    end
  end

endmodule

`default_nettype wire
